/* rtl/u8dv_pkg.sv */
// shared types and constants for the utf-8 stream decoder and validator
package u8dv_pkg;

    // depth of the queue between the classifier and the decoder
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // result field widths
    localparam int CODE_W      = 21;
    localparam int CHAR_CNT_W  = 16;

    // byte patterns used by the classifier and the decoder
    localparam logic [7:0] LEAD_E0 = 8'he0;
    localparam logic [7:0] LEAD_ED = 8'hed;
    localparam logic [7:0] LEAD_EF = 8'hef;
    localparam logic [7:0] LEAD_F0 = 8'hf0;
    localparam logic [7:0] LEAD_F4 = 8'hf4;
    localparam logic [7:0] CONT_BF = 8'hbf;

    // one classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_ascii;
        logic       is_lead2;
        logic       is_lead3;
        logic       is_lead4;
        logic       is_cont;
        logic       low_e0;    // 80..9f, overlong after e0
        logic       high_ed;   // a0..bf, surrogate after ed
        logic       low_f0;    // 80..8f, overlong after f0
        logic       above_8f;  // above 8f, out of range after f4
        logic       is_be_bf;  // be or bf, noncharacter after ef bf
    } byte_class_t;

endpackage

/* rtl/u8dv_front.sv */
// byte classifier: sorts each incoming byte by the roles it can play
module u8dv_front (
    input  logic [7:0]           data_byte,
    input  logic                 end_of_string,
    output u8dv_pkg::byte_class_t cls
);
    import u8dv_pkg::*;

    // lead and continuation decode, independent of decoder state
    always_comb
    begin
        cls.data     = data_byte;
        cls.last     = end_of_string;
        cls.is_ascii = (data_byte[7] == 1'b0);
        cls.is_lead2 = ((data_byte & 8'he0) == 8'hc0) && ((data_byte & 8'hfe) != 8'hc0);
        cls.is_lead3 = ((data_byte & 8'hf0) == 8'he0);
        cls.is_lead4 = ((data_byte & 8'hf8) == 8'hf0) && (data_byte <= LEAD_F4);
        cls.is_cont  = ((data_byte & 8'hc0) == 8'h80);
        cls.low_e0   = ((data_byte & 8'he0) == 8'h80);
        cls.high_ed  = ((data_byte & 8'he0) == 8'ha0);
        cls.low_f0   = ((data_byte & 8'hf0) == 8'h80);
        cls.above_8f = (data_byte > 8'h8f);
        cls.is_be_bf = ((data_byte & 8'hfe) == 8'hbe);
    end

endmodule

/* rtl/u8dv_queue.sv */
// small fifo of classified bytes between the classifier and the decoder
module u8dv_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8dv_pkg::byte_class_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output u8dv_pkg::byte_class_t head
);
    import u8dv_pkg::*;

    byte_class_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/u8dv_back.sv */
// sequence decoder: assembles code points, checks forms, keeps string summary
module u8dv_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  u8dv_pkg::byte_class_t           head,
    output logic                            head_pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [u8dv_pkg::CODE_W-1:0]     code_point,
    output logic                            char_done,
    output logic                            error_found,
    output logic                            summary_flag,
    output logic                            string_valid,
    output logic [u8dv_pkg::CHAR_CNT_W-1:0] char_count
);
    import u8dv_pkg::*;

    // decoder state
    logic [1:0]             pending_reg, pending_next;
    logic [7:0]             lead_reg, lead_next;
    logic [7:0]             second_reg, second_next;
    logic [CODE_W-1:0]      partial_reg, partial_next;
    logic [COUNT_WIDTH-1:0] seen_reg, seen_next;
    logic                   latched_reg, latched_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]      code_reg;
    logic                   done_reg, err_reg, last_reg, valid_str_reg;
    logic [CHAR_CNT_W-1:0]  count_out_reg, count_out;

    logic                   fire, done, err, emit, bad_cont;
    logic [2:0]             seq_len;
    logic                   at_second, at_third;

    // take the queue head whenever the output register can accept a result
    assign fire     = head_valid && (!out_valid_reg || !result_stall);
    assign head_pop = fire;

    // sequence length and byte position of the sequence in progress
    always_comb
    begin
        if ((lead_reg & 8'he0) == 8'hc0)
        begin
            seq_len = 3'd2;
        end
        else if ((lead_reg & 8'hf0) == 8'he0)
        begin
            seq_len = 3'd3;
        end
        else
        begin
            seq_len = 3'd4;
        end
        at_second = (seq_len - {1'b0, pending_reg}) == 3'd1;
        at_third  = (seq_len - {1'b0, pending_reg}) == 3'd2;
    end

    // continuation check against overlong, surrogate, range and noncharacter limits
    always_comb
    begin
        bad_cont = !head.is_cont;
        if (at_second)
        begin
            if ((lead_reg == LEAD_E0 && head.low_e0) ||
                (lead_reg == LEAD_ED && head.high_ed) ||
                (lead_reg == LEAD_F0 && head.low_f0) ||
                (lead_reg == LEAD_F4 && head.above_8f))
            begin
                bad_cont = 1'b1;
            end
        end
        else if (at_third && seq_len == 3'd3)
        begin
            if (lead_reg == LEAD_EF && second_reg == CONT_BF && head.is_be_bf)
            begin
                bad_cont = 1'b1;
            end
        end
    end

    // per-byte decode step
    always_comb
    begin
        pending_next = pending_reg;
        lead_next    = lead_reg;
        second_next  = second_reg;
        partial_next = partial_reg;
        seen_next    = seen_reg;
        latched_next = latched_reg;
        done         = 1'b0;
        err          = 1'b0;
        if (!latched_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                if (head.is_ascii)
                begin
                    partial_next = {13'd0, head.data};
                    done         = 1'b1;
                end
                else if (head.is_lead2)
                begin
                    pending_next = 2'd1;
                    partial_next = {16'd0, head.data[4:0]};
                    lead_next    = head.data;
                end
                else if (head.is_lead3)
                begin
                    pending_next = 2'd2;
                    partial_next = {17'd0, head.data[3:0]};
                    lead_next    = head.data;
                end
                else if (head.is_lead4)
                begin
                    pending_next = 2'd3;
                    partial_next = {18'd0, head.data[2:0]};
                    lead_next    = head.data;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            else
            begin
                if (bad_cont)
                begin
                    err = 1'b1;
                end
                else
                begin
                    if (at_second)
                    begin
                        second_next = head.data;
                    end
                    partial_next = {partial_reg[CODE_W-7:0], head.data[5:0]};
                    pending_next = pending_reg - 2'd1;
                    done         = (pending_reg == 2'd1);
                end
            end
            if (done && !(&seen_reg))
            begin
                seen_next = seen_reg + 1'b1;
            end
            if (head.last && !err && pending_next != 2'd0)
            begin
                err = 1'b1;
            end
            if (err)
            begin
                latched_next = 1'b1;
                pending_next = 2'd0;
            end
        end
    end

    assign emit = done || err || head.last;

    // count seen by the result field, saturated to its width when wider, else zero-extended
    generate
        if (COUNT_WIDTH > CHAR_CNT_W)
        begin : g_sat
            assign count_out = (|seen_next[COUNT_WIDTH-1:CHAR_CNT_W]) ? '1
                                                                    : seen_next[CHAR_CNT_W-1:0];
        end
        else
        begin : g_ext
            assign count_out = CHAR_CNT_W'(seen_next);
        end
    endgenerate

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            lead_reg      <= '0;
            second_reg    <= '0;
            partial_reg   <= '0;
            seen_reg      <= '0;
            latched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                lead_reg    <= lead_next;
                second_reg  <= second_next;
                partial_reg <= partial_next;
                if (head.last)
                begin
                    pending_reg <= '0;
                    seen_reg    <= '0;
                    latched_reg <= 1'b0;
                end
                else
                begin
                    pending_reg <= pending_next;
                    seen_reg    <= seen_next;
                    latched_reg <= latched_next;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            code_reg      <= done ? partial_next : '0;
            done_reg      <= done;
            err_reg       <= err;
            last_reg      <= head.last;
            valid_str_reg <= head.last && !latched_next;
            count_out_reg <= count_out;
        end
    end

    assign result_valid = out_valid_reg;
    assign code_point   = code_reg;
    assign char_done    = done_reg;
    assign error_found  = err_reg;
    assign summary_flag = last_reg;
    assign string_valid = valid_str_reg;
    assign char_count   = count_out_reg;

endmodule

/* rtl/utf8_stream_decode_validate.sv */
// top level of the utf-8 stream decoder and validator
//
//  channel   | handshake                  | fields
//  ----------+----------------------------+---------------------------------------------
//  byte in   | byte_valid / byte_stall    | data_byte, end_of_string
//  result    | result_valid / result_stall| code_point, char_done, error_found,
//            |                            | summary_flag, string_valid, char_count
//
//  one byte per cycle while no result stalls; a result is registered after its byte is taken,
//  passing first the queue entry, then the decoder's output register
//  rst_n clears the queue, the decoder state and the result valid flag at once
//  a stalled result holds the output register and stops the decoder; the four-entry
//  queue keeps taking bytes until full, then byte_stall rises
module utf8_stream_decode_validate #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    output logic                            byte_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            end_of_string,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [u8dv_pkg::CODE_W-1:0]     code_point,
    output logic                            char_done,
    output logic                            error_found,
    output logic                            summary_flag,
    output logic                            string_valid,
    output logic [u8dv_pkg::CHAR_CNT_W-1:0] char_count
);
    import u8dv_pkg::*;

    byte_class_t cls, head;
    logic        q_full, q_not_empty, q_pop, q_push;

    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    // classify incoming bytes
    u8dv_front u_front (
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .cls           (cls)
    );

    // decouple classifier from decoder
    u8dv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // decode sequences and produce results
    u8dv_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_not_empty),
        .head         (head),
        .head_pop     (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .char_done    (char_done),
        .error_found  (error_found),
        .summary_flag (summary_flag),
        .string_valid (string_valid),
        .char_count   (char_count)
    );

endmodule

/* rtl/u8dv_checker.sv */
// port-level assertions for the utf-8 decoder, bound to the top level
module u8dv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [20:0] code_point,
    input logic        char_done,
    input logic        error_found,
    input logic        summary_flag,
    input logic        string_valid
);

    // a stalled result request stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result request dropped while stalled");

    // a decoded character is within the code point range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && char_done |-> code_point <= 21'h10ffff)
        else $error("code point out of range");

    // no character and error on the same byte, code point zero without a character
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(char_done && error_found) && (char_done || code_point == 21'd0))
        else $error("inconsistent character and error flags");

    // validity only with the summary, never on the error byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && string_valid |-> summary_flag && !error_found)
        else $error("string validity outside a clean summary");

endmodule

bind utf8_stream_decode_validate u8dv_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .code_point   (code_point),
    .char_done    (char_done),
    .error_found  (error_found),
    .summary_flag (summary_flag),
    .string_valid (string_valid)
);
